@@ rtl/core/fbsc_pkg.sv @@
package fbsc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int COEF_W     = 16;
	localparam int COORD_W    = 32;
	localparam int RADIUS_W   = 31;
	localparam int FLAGS_W    = 8;
	localparam int PROD_W     = COEF_W + COORD_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int D_SHIFT    = 16;
	localparam int R_SHIFT    = 14;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 6;
	localparam int IDX_W      = 3;
	localparam int BIT_SEL_W  = 3;
	localparam int SKIP_BIT   = 7;

	localparam logic [IDX_W-1:0] REG_ACTIVE_PLANES = 3'd6;
	localparam logic [IDX_W-1:0] REG_RESULT_BIT    = 3'd7;

	localparam logic [2:0] ACTIVE_PLANES_RESET = 3'd6;
	localparam logic [2:0] RESULT_BIT_RESET    = 3'd0;

	localparam logic OP_BOX    = 1'b0;
	localparam logic OP_SPHERE = 1'b1;

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coef_t d;
		coef_t c;
		coef_t b;
		coef_t a;
	} plane_t;

endpackage

@@ rtl/core/fbsc_if.sv @@
interface fbsc_item_if;
	import fbsc_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	coord_t              ax;
	coord_t              ay;
	coord_t              az;
	coord_t              bx;
	coord_t              by;
	coord_t              bz;
	logic [RADIUS_W-1:0] radius;
	logic [FLAGS_W-1:0]  flags_in;
	logic                last_item;

	modport source (
		output valid, op, ax, ay, az, bx, by, bz, radius, flags_in, last_item,
		input  ready
	);
	modport sink (
		input  valid, op, ax, ay, az, bx, by, bz, radius, flags_in, last_item,
		output ready
	);
endinterface

interface fbsc_result_if;
	import fbsc_pkg::*;

	logic               valid;
	logic               ready;
	logic               passed;
	logic [FLAGS_W-1:0] flags_out;
	logic               last_result;

	modport source (
		output valid, passed, flags_out, last_result,
		input  ready
	);
	modport sink (
		input  valid, passed, flags_out, last_result,
		output ready
	);
endinterface

@@ rtl/core/frustum_box_sphere_cull_unit.sv @@
// Channel   Direction  Payload
// item      in         op, ax..az, bx..bz, radius, flags_in, last_item
// result    out        passed, flags_out, last_result
// config    APB        plane_0..plane_5, active_planes, result_bit (64-bit data)
//
// One item is taken every cycle while the result channel is not stalled; an item passes
// through the input register, multiply stage, partial-sum stage and result register.
// The three multipliers per plane (16 by 32 bits) set the depth of the pipeline.
// Reset clears the plane registers and result_bit, sets active_planes to 6, and clears all stage valid bits.
// Each stage moves on when the stage after it is empty or moving, so the block
// keeps taking items while a result waits, until every stage is full.
module frustum_box_sphere_cull_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fbsc_pkg::ADDR_W-1:0] paddr,
	input  logic [fbsc_pkg::DATA_W-1:0] pwdata,
	output logic [fbsc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	fbsc_item_if.sink                  item,
	fbsc_result_if.source              result
);
	import fbsc_pkg::*;

	plane_t         plane_q [NUM_PLANES];
	logic [2:0]     active_q;
	logic [BIT_SEL_W-1:0] result_bit_q;
	logic [IDX_W-1:0] reg_idx;
	logic           cfg_wr;

	logic en_s1, en_s2, en_s3, en_out;
	logic v_s1, v_s2, v_s3, res_valid_q;

	logic                op_s1, op_s2;
	coord_t              ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic [RADIUS_W-1:0] radius_s1, radius_s2;
	logic [FLAGS_W-1:0]  flags_s1, flags_s2, flags_s3;
	logic                last_s1, last_s2, last_s3;

	coord_t                   xsel [NUM_PLANES];
	coord_t                   ysel [NUM_PLANES];
	coord_t                   zsel [NUM_PLANES];
	logic signed [PROD_W-1:0] px_s2 [NUM_PLANES];
	logic signed [PROD_W-1:0] py_s2 [NUM_PLANES];
	logic signed [PROD_W-1:0] pz_s2 [NUM_PLANES];
	logic signed [SUM_W-1:0]  r_term;
	logic signed [SUM_W-1:0]  sum01_s3 [NUM_PLANES];
	logic signed [SUM_W-1:0]  sum23_s3 [NUM_PLANES];
	logic signed [SUM_W-1:0]  sum_v [NUM_PLANES];
	logic [NUM_PLANES-1:0]    plane_ok;
	logic                     all_ok;
	logic [FLAGS_W-1:0]       flags_next;

	logic               passed_q;
	logic [FLAGS_W-1:0] flags_out_q;
	logic               last_q;

	// Configuration port: registers sit at 8-byte strides.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
			active_q     <= ACTIVE_PLANES_RESET;
			result_bit_q <= RESULT_BIT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ACTIVE_PLANES: active_q     <= pwdata[2:0];
				REG_RESULT_BIT:    result_bit_q <= pwdata[BIT_SEL_W-1:0];
				default:           plane_q[reg_idx] <= plane_t'(pwdata);
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ACTIVE_PLANES: prdata = DATA_W'(active_q);
			REG_RESULT_BIT:    prdata = DATA_W'(result_bit_q);
			default:           prdata = DATA_W'(plane_q[reg_idx]);
		endcase
	end

	// Stage flow control.
	assign en_out     = !res_valid_q || result.ready;
	assign en_s3      = !v_s3 || en_out;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= item.valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_out) res_valid_q <= v_s3;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) begin
			op_s1     <= item.op;
			ax_s1     <= item.ax;
			ay_s1     <= item.ay;
			az_s1     <= item.az;
			bx_s1     <= item.bx;
			by_s1     <= item.by;
			bz_s1     <= item.bz;
			radius_s1 <= item.radius;
			flags_s1  <= item.flags_in;
			last_s1   <= item.last_item;
		end
	end

	// A box takes the corner nearest the inner side of each plane.
	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			xsel[i] = (op_s1 == OP_BOX && plane_q[i].a < 0) ? bx_s1 : ax_s1;
			ysel[i] = (op_s1 == OP_BOX && plane_q[i].b < 0) ? by_s1 : ay_s1;
			zsel[i] = (op_s1 == OP_BOX && plane_q[i].c < 0) ? bz_s1 : az_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				px_s2[i] <= plane_q[i].a * xsel[i];
				py_s2[i] <= plane_q[i].b * ysel[i];
				pz_s2[i] <= plane_q[i].c * zsel[i];
			end
			op_s2     <= op_s1;
			radius_s2 <= radius_s1;
			flags_s2  <= flags_s1;
			last_s2   <= last_s1;
		end
	end

	// A sphere compares against its radius by subtracting it from the plane value.
	assign r_term = (op_s2 == OP_SPHERE)
		? SUM_W'($signed({1'b0, radius_s2, {R_SHIFT{1'b0}}})) : '0;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				sum01_s3[i] <= SUM_W'(px_s2[i]) + SUM_W'(py_s2[i]);
				sum23_s3[i] <= SUM_W'(pz_s2[i]) + (SUM_W'(plane_q[i].d) <<< D_SHIFT)
					- r_term;
			end
			flags_s3 <= flags_s2;
			last_s3  <= last_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			sum_v[i]    = sum01_s3[i] + sum23_s3[i];
			plane_ok[i] = (!sum_v[i][SUM_W-1] && (sum_v[i] != '0))
				|| !(active_q > IDX_W'(i));
		end
		all_ok     = &plane_ok;
		flags_next = flags_s3;
		if (!flags_s3[SKIP_BIT] && all_ok) begin
			flags_next = flags_s3 | (FLAGS_W'(1) << result_bit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			passed_q    <= all_ok;
			flags_out_q <= flags_next;
			last_q      <= last_s3;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.passed      = passed_q;
	assign result.flags_out   = flags_out_q;
	assign result.last_result = last_q;

endmodule

@@ rtl/core/fbsc_checker.sv @@
module fbsc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_passed,
	input logic [fbsc_pkg::FLAGS_W-1:0] res_flags,
	input logic                         res_last
);
	import fbsc_pkg::*;

	logic [2:0] cnt_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_passed)
			&& $stable(res_flags) && $stable(res_last))
		else $error("result changed while stalled");

	// No result appears without an outstanding item.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != 3'd0)
		else $error("result without an item in flight");

	// The four stages bound the number of items in flight.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("more items in flight than stages");

	// An empty block always takes a transfer.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> in_ready)
		else $error("empty block refused an item");

endmodule

bind frustum_box_sphere_cull_unit fbsc_checker u_fbsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_passed(result.passed),
	.res_flags (result.flags_out),
	.res_last  (result.last_result)
);
